/* src/fsgd_pkg.sv */
// Shared types, constants and quantiser tables for the gray error-diffusion dither.
// Used by the datapath, the controller and the top level; depends on nothing.
package fsgd_pkg;

    localparam int PIX_W          = 8;
    localparam int ERR_W          = 9;
    localparam int LEVEL_BITS_W   = 4;
    localparam int LINE_WIDTH_W   = 12;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 12;
    localparam int RECIP_W        = 16;
    localparam int MAX_WIDTH_DEFAULT = 2048;

    localparam logic [CFG_IDX_W-1:0]    CFG_LEVEL_BITS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0]    CFG_LINE_WIDTH   = 1'b1;
    localparam logic [LEVEL_BITS_W-1:0] LEVEL_BITS_RESET = 4'd1;
    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 12'd640;

    typedef enum logic [2:0] {
        SHARE_NONE,
        SHARE_UL,
        SHARE_UP,
        SHARE_UR,
        SHARE_LEFT
    } t_share;

    typedef struct packed {
        logic   load;
        logic   rd_top;
        logic   cap_up;
        logic   cap_ur;
        t_share share;
        logic   quant_est;
        logic   quant_fix;
        logic   commit;
    } t_dp_cmd;

    typedef struct packed {
        logic col_zero_next;
    } t_dp_status;

    // Quantiser step, 255 div (2^bits - 1); zero bits acts as one, above eight as eight.
    function automatic logic [PIX_W-1:0] step_of(input logic [LEVEL_BITS_W-1:0] bits);
        logic [PIX_W-1:0] s;
        unique case (bits)
            4'd0, 4'd1: s = 8'd255;
            4'd2:       s = 8'd85;
            4'd3:       s = 8'd36;
            4'd4:       s = 8'd17;
            4'd5:       s = 8'd8;
            4'd6:       s = 8'd4;
            4'd7:       s = 8'd2;
            default:    s = 8'd1;
        endcase
        return s;
    endfunction

    // Highest multiple of the step that stays within 255.
    function automatic logic [PIX_W-1:0] top_of(input logic [LEVEL_BITS_W-1:0] bits);
        logic [PIX_W-1:0] t;
        unique case (bits)
            4'd0, 4'd1: t = 8'd255;
            4'd2:       t = 8'd255;
            4'd3:       t = 8'd252;
            4'd4:       t = 8'd255;
            4'd5:       t = 8'd248;
            4'd6:       t = 8'd252;
            4'd7:       t = 8'd254;
            default:    t = 8'd255;
        endcase
        return t;
    endfunction

    // floor(2^16 / (2 * step)); the estimate it gives is never high and at most one low.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [LEVEL_BITS_W-1:0] bits);
        logic [RECIP_W-1:0] m;
        unique case (bits)
            4'd0, 4'd1: m = 16'd128;
            4'd2:       m = 16'd385;
            4'd3:       m = 16'd910;
            4'd4:       m = 16'd1927;
            4'd5:       m = 16'd4096;
            4'd6:       m = 16'd8192;
            4'd7:       m = 16'd16384;
            default:    m = 16'd32768;
        endcase
        return m;
    endfunction

endpackage

/* src/fsgd_ram.sv */
// Generic simple dual-port RAM: one write port and one registered read port.
// Stand-alone; no package needed.
module fsgd_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/fsgd_datapath.sv */
// Datapath of the dither: configuration, line error store, share adder and quantiser.
// Depends on fsgd_pkg and fsgd_ram.
module fsgd_datapath
    import fsgd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_status,
    input  logic [PIX_W-1:0]        i_pixel_in,
    input  logic                    i_frame_start,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output logic [PIX_W-1:0]        o_pixel_out
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (XW + 1 > LINE_WIDTH_W) ? XW + 1 : LINE_WIDTH_W;

    logic [LEVEL_BITS_W-1:0] r_level_bits;
    logic [LINE_WIDTH_W-1:0] r_line_width;

    logic signed [ERR_W-1:0] r_left, r_aw1, r_aw2;
    logic [XW-1:0]           r_column;
    logic                    r_on_first;

    logic [PIX_W-1:0]        r_pix;
    logic [XW-1:0]           r_x;
    logic                    r_first, r_last, r_col_zero;
    logic signed [ERR_W-1:0] r_ul, r_up, r_ur;
    logic [9:0]              r_n;
    logic [8:0]              r_est;
    logic [8:0]              r_k;
    logic [PIX_W-1:0]        r_pix_out;

    logic                    col_zero_next;
    logic [XW-1:0]           x_next;
    logic [XW:0]             x_next1;
    logic [XW:0]             x1;
    logic [CMPW-1:0]         w0, w_eff;
    logic                    last_next;

    logic                    share_en;
    logic signed [ERR_W-1:0] share_e;
    logic [2:0]              share_k;

    logic [PIX_W-1:0]        d, top;
    logic [RECIP_W-1:0]      m;
    logic [8:0]              two_d;
    logic [9:0]              n;
    logic [24:0]             prod;
    logic [17:0]             prod2, rem;
    logic [16:0]             q_full;
    logic [PIX_W-1:0]        q;
    logic signed [ERR_W-1:0] err;

    logic [XW-1:0]           ram_raddr;
    logic [ERR_W-1:0]        ram_rdata;

    function automatic logic [PIX_W-1:0] add_share(
        input logic [PIX_W-1:0]        v,
        input logic signed [ERR_W-1:0] e,
        input logic [2:0]              k
    );
        logic signed [12:0] p;
        logic signed [12:0] s;
        logic signed [10:0] t;
        logic [PIX_W-1:0]   r;
        p = e * $signed({1'b0, k});
        s = p[12] ? ((p + 13'sd15) >>> 4) : (p >>> 4);
        t = $signed({3'b000, v}) + $signed(s[10:0]);
        if (t < 0) begin
            r = 8'd0;
        end else if (t > 11'sd255) begin
            r = 8'd255;
        end else begin
            r = t[7:0];
        end
        return r;
    endfunction

    // Column, row flags and row end for the pixel being transferred.
    always_comb begin
        col_zero_next = i_frame_start || (r_column == '0);
        x_next        = i_frame_start ? '0 : r_column;
        x_next1       = {1'b0, x_next} + {{XW{1'b0}}, 1'b1};
        w0            = (r_line_width == '0) ? CMPW'(1) : CMPW'(r_line_width);
        w_eff         = (w0 > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : w0;
        last_next     = CMPW'(x_next1) >= w_eff;
        x1            = {1'b0, r_x} + {{XW{1'b0}}, 1'b1};
    end

    assign o_status.col_zero_next = col_zero_next;

    always_comb begin
        unique case (i_cmd.share)
            SHARE_NONE: begin
                share_en = 1'b0; share_e = '0;     share_k = 3'd0;
            end
            SHARE_UL: begin
                share_en = !r_first && !r_col_zero; share_e = r_ul; share_k = 3'd1;
            end
            SHARE_UP: begin
                share_en = !r_first; share_e = r_up; share_k = 3'd5;
            end
            SHARE_UR: begin
                share_en = !r_first && !r_last; share_e = r_ur; share_k = 3'd3;
            end
            SHARE_LEFT: begin
                share_en = !r_col_zero; share_e = r_left; share_k = 3'd7;
            end
            default: begin
                share_en = 1'b0; share_e = '0;     share_k = 3'd0;
            end
        endcase
    end

    // Rounding quotient by reciprocal estimate and a single correction.
    always_comb begin
        d      = step_of(r_level_bits);
        top    = top_of(r_level_bits);
        m      = recip_of(r_level_bits);
        two_d  = {d, 1'b0};
        n      = {1'b0, r_pix, 1'b0} + {2'b00, d};
        prod   = {15'd0, n} * {9'd0, m};
        prod2  = {9'd0, r_est} * {9'd0, two_d};
        rem    = {8'd0, r_n} - prod2;
        q_full = {8'd0, r_k} * {9'd0, d};
        q      = (q_full >= {9'd0, top}) ? 8'd255 : q_full[7:0];
        err    = $signed({1'b0, r_pix}) - $signed({1'b0, q});
    end

    assign ram_raddr = i_cmd.rd_top ? '0 : x1[XW-1:0];

    fsgd_ram #(
        .WIDTH (ERR_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_x),
        .i_wdata (err),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_bits <= LEVEL_BITS_RESET;
            r_line_width <= LINE_WIDTH_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_LEVEL_BITS) begin
                r_level_bits <= i_cfg_data[LEVEL_BITS_W-1:0];
            end else begin
                r_line_width <= i_cfg_data[LINE_WIDTH_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= '0;
            r_aw1      <= '0;
            r_aw2      <= '0;
            r_column   <= '0;
            r_on_first <= 1'b1;
        end else if (i_cmd.commit) begin
            r_left     <= err;
            r_aw1      <= r_up;
            r_aw2      <= r_ur;
            r_column   <= r_last ? '0 : x1[XW-1:0];
            r_on_first <= r_last ? 1'b0 : r_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix      <= i_pixel_in;
            r_x        <= x_next;
            r_first    <= i_frame_start || r_on_first;
            r_col_zero <= col_zero_next;
            r_last     <= last_next;
            r_ul       <= col_zero_next ? '0 : r_aw1;
        end else if (share_en) begin
            r_pix <= add_share(r_pix, share_e, share_k);
        end
        if (i_cmd.cap_up) begin
            r_up <= r_col_zero ? $signed(ram_rdata) : r_aw2;
        end
        if (i_cmd.cap_ur) begin
            r_ur <= r_last ? '0 : $signed(ram_rdata);
        end
        if (i_cmd.quant_est) begin
            r_n   <= n;
            r_est <= prod[24:16];
        end
        if (i_cmd.quant_fix) begin
            r_k <= (rem >= {9'd0, two_d}) ? r_est + 9'd1 : r_est;
        end
        if (i_cmd.commit) begin
            r_pix_out <= q;
        end
    end

    assign o_pixel_out = r_pix_out;

endmodule

/* src/fsgd_ctrl.sv */
// Controller of the dither: sequences reads, shares, quantiser and commit per pixel.
// Depends on fsgd_pkg.
module fsgd_ctrl
    import fsgd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_TOP,
        S_RD_NEXT,
        S_SH_UL,
        S_SH_UP,
        S_SH_UR,
        S_SH_LEFT,
        S_Q_EST,
        S_Q_FIX,
        S_COMMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    always_comb begin
        slot_free   = !r_out_valid || i_ready;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd       = '0;
        o_cmd.share = SHARE_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && r_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.col_zero_next ? S_RD_TOP : S_RD_NEXT;
                end
            end
            S_RD_TOP: begin
                o_cmd.rd_top = 1'b1;
                n_state      = S_RD_NEXT;
            end
            S_RD_NEXT: begin
                o_cmd.cap_up = 1'b1;
                n_state      = S_SH_UL;
            end
            S_SH_UL: begin
                o_cmd.cap_ur = 1'b1;
                o_cmd.share  = SHARE_UL;
                n_state      = S_SH_UP;
            end
            S_SH_UP: begin
                o_cmd.share = SHARE_UP;
                n_state     = S_SH_UR;
            end
            S_SH_UR: begin
                o_cmd.share = SHARE_UR;
                n_state     = S_SH_LEFT;
            end
            S_SH_LEFT: begin
                o_cmd.share = SHARE_LEFT;
                n_state     = S_Q_EST;
            end
            S_Q_EST: begin
                o_cmd.quant_est = 1'b1;
                n_state         = S_Q_FIX;
            end
            S_Q_FIX: begin
                o_cmd.quant_fix = 1'b1;
                n_state         = S_COMMIT;
            end
            S_COMMIT: begin
                if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = r_in_ready;
    assign o_valid = r_out_valid;

endmodule

/* src/floyd_steinberg_gray_dither.sv */
// Top level of the gray error-diffusion dither: controller, datapath and checks.
// Depends on fsgd_pkg, fsgd_ctrl and fsgd_datapath.
//
//  Channel   Direction  Handshake           Payload
//  pixel in  input      i_valid / o_ready   i_pixel_in, i_frame_start
//  pixel out output     o_valid / i_ready   o_pixel_out
//  config    input      i_cfg_we            i_cfg_index, i_cfg_data
//
// One pixel is processed at a time; column zero adds the state S_RD_TOP, where the single
// read port of the line store is used twice.
// A result passes from its transfer through the read, share, quantiser and commit states.
// The four shares are added one per cycle, and the quantiser divides in two steps.
// Reset is synchronous and active low; the line store needs no clearing pass.
// The next pixel is taken while a result waits; only the commit waits on the output.
module floyd_steinberg_gray_dither
    import fsgd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PIX_W-1:0]      i_pixel_in,
    input  logic                  i_frame_start,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIX_W-1:0]      o_pixel_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    fsgd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    fsgd_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_pixel_in    (i_pixel_in),
        .i_frame_start (i_frame_start),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pixel_out   (o_pixel_out)
    );

    a_busy_after_transfer: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready
    ) else $error("input ready stayed high after a transfer");

    a_commit_slot_free: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_valid || i_ready)
    ) else $error("result committed over an untaken result");

    a_load_only_when_ready: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (o_ready && i_valid)
    ) else $error("pixel loaded without a transfer");

    a_reset_state: assert property (
        @(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready)
    ) else $error("handshake outputs wrong after reset");

endmodule

/* sim/floyd_steinberg_gray_dither_tb.sv */
// Self-checking testbench for the gray error-diffusion dither, with its own pixel predictor.
// Drives directed and random frames through valid/ready with idling and a long hold-off.
// Depends on fsgd_pkg and floyd_steinberg_gray_dither.
`timescale 1ns / 100ps

module floyd_steinberg_gray_dither_tb;
    import fsgd_pkg::*;

    localparam int LINE_MAX       = MAX_WIDTH_DEFAULT;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [PIX_W-1:0]      i_pixel_in = '0;
    logic                  i_frame_start = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [PIX_W-1:0]      o_pixel_out;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_LEVEL_BITS;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predictor state and register copies.
    logic [LEVEL_BITS_W-1:0] model_level_bits = LEVEL_BITS_RESET;
    logic [LINE_WIDTH_W-1:0] model_line_width = LINE_WIDTH_RESET;
    logic signed [ERR_W-1:0] prev_row_err [LINE_MAX];
    logic signed [ERR_W-1:0] left_err = '0;
    logic signed [ERR_W-1:0] win_up = '0;
    logic signed [ERR_W-1:0] win_right = '0;
    logic [10:0]             next_col = '0;
    logic                    top_row = 1'b1;

    logic [PIX_W-1:0] expected_pixels[$];
    logic [PIX_W-1:0] want_pixel;
    int               mismatch_count = 0;
    int               pixel_count = 0;
    int               result_count = 0;
    int               config_count = 0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               idle_cycles = 0;
    logic             hold_on = 1'b0;
    event             hold_off_ev;

    floyd_steinberg_gray_dither uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel_in   (i_pixel_in),
        .i_frame_start(i_frame_start),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_out  (o_pixel_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int clip_pixel(input int v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] dither_pixel(input logic [PIX_W-1:0] pix,
                                                       input logic fs);
        int   bits, width, x, v, q, err, ul, up, ur, step, top, left;
        logic is_last;
        bits = model_level_bits;
        if (bits < 1) bits = 1;
        if (bits > 8) bits = 8;
        width = model_line_width;
        if (width < 1) width = 1;
        if (width > LINE_MAX) width = LINE_MAX;
        if (fs) begin
            next_col = '0;
            top_row = 1'b1;
        end
        x = next_col;
        is_last = (x + 1 >= width);
        if (x == 0) begin
            ul = 0;
            up = prev_row_err[0];
        end else begin
            ul = win_up;
            up = win_right;
        end
        ur = (!is_last && x + 1 < LINE_MAX) ? int'(prev_row_err[x + 1]) : 0;
        left = left_err;
        v = pix;
        if (!top_row) begin
            if (x > 0) v = clip_pixel(v + ul / 16);
            v = clip_pixel(v + up * 5 / 16);
            if (!is_last) v = clip_pixel(v + ur * 3 / 16);
        end
        if (x > 0) v = clip_pixel(v + left * 7 / 16);
        step = 255 / ((1 << bits) - 1);
        top = (255 / step) * step;
        q = ((2 * v + step) / (2 * step)) * step;
        if (q >= top) q = 255;
        err = v - q;
        win_up = ERR_W'(up);
        win_right = ERR_W'(ur);
        prev_row_err[x] = ERR_W'(err);
        left_err = ERR_W'(err);
        if (is_last) begin
            next_col = '0;
            top_row = 1'b0;
        end else begin
            next_col = 11'(x + 1);
        end
        return PIX_W'(q);
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_in <= pix;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_pixels.push_back(dither_pixel(pix, fs));
        pixel_count++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_LEVEL_BITS) model_level_bits = data[LEVEL_BITS_W-1:0];
        else model_line_width = data[LINE_WIDTH_W-1:0];
    endtask

    task automatic apply_config(input logic [LEVEL_BITS_W-1:0] bits,
                                input logic [LINE_WIDTH_W-1:0] width);
        wait_idle();
        write_reg(CFG_LEVEL_BITS, CFG_DATA_W'(bits));
        write_reg(CFG_LINE_WIDTH, width);
        i_cfg_we <= 1'b0;
        config_count++;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct <= receiver_pct;
    endtask

    task automatic test_no_frame_start();
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd128, 1'b0);
    endtask

    task automatic test_level_bits_clamp();
        logic [PIX_W-1:0] low_vals [5] = '{8'd200, 8'd60, 8'd255, 8'd0, 8'd127};
        logic [PIX_W-1:0] high_vals [5] = '{8'd128, 8'd1, 8'd254, 8'd90, 8'd170};
        apply_config(4'd0, 12'd3);
        foreach (low_vals[i]) send_pixel(low_vals[i], i == 0);
        apply_config(4'd15, 12'd3);
        foreach (high_vals[i]) send_pixel(high_vals[i], i == 0);
    endtask

    task automatic test_width_zero();
        apply_config(4'd2, 12'd0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd127, 1'b0);
        send_pixel(8'd128, 1'b0);
    endtask

    task automatic test_width_shrink_mid_row();
        logic [PIX_W-1:0] row_vals [5] = '{8'd10, 8'd250, 8'd100, 8'd200, 8'd37};
        apply_config(4'd3, 12'd6);
        foreach (row_vals[i]) send_pixel(row_vals[i], i == 0);
        apply_config(4'd3, 12'd2);
        send_pixel(8'd240, 1'b0);
        send_pixel(8'd15, 1'b0);
        send_pixel(8'd128, 1'b0);
    endtask

    task automatic test_width_beyond_max();
        apply_config(4'd4, 12'd4095);
        for (int i = 0; i < 24; i++) send_pixel(PIX_W'($urandom), i == 0);
    endtask

    task automatic test_receiver_hold();
        apply_config(4'd8, 12'd5);
        -> hold_off_ev;
        for (int i = 0; i < 40; i++) send_pixel(PIX_W'($urandom), i == 0);
    endtask

    task automatic test_random_frames(input int n_items);
        int                      sent, phase_len, base;
        bit                      flat;
        logic [LEVEL_BITS_W-1:0] bits;
        logic [LINE_WIDTH_W-1:0] width;
        logic [PIX_W-1:0]        pix;
        sent = 0;
        while (sent < n_items) begin
            bits = LEVEL_BITS_W'($urandom_range(0, 15));
            width = ($urandom_range(0, 5) == 0) ? LINE_WIDTH_W'($urandom_range(25, 160))
                                                : LINE_WIDTH_W'($urandom_range(1, 24));
            phase_len = $urandom_range(20, 60);
            flat = 1'($urandom_range(0, 1));
            base = int'($urandom_range(0, 255));
            apply_config(bits, width);
            for (int i = 0; i < phase_len; i++) begin
                if (flat) pix = PIX_W'(clip_pixel(base + int'($urandom_range(0, 16)) - 8));
                else pix = PIX_W'($urandom);
                send_pixel(pix, (i == 0) || ($urandom_range(0, 49) == 0));
            end
            sent += phase_len;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_on) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        forever begin
            @(hold_off_ev);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_on <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            result_count++;
            if (expected_pixels.size() == 0) begin
                $error("pixel_out transfer with nothing expected: actual %0d", o_pixel_out);
                mismatch_count++;
            end else begin
                want_pixel = expected_pixels.pop_front();
                if (o_pixel_out !== want_pixel) begin
                    $error("pixel_out mismatch: expected %0d, actual %0d",
                           want_pixel, o_pixel_out);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        foreach (prev_row_err[i]) prev_row_err[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(32, 53);
        test_no_frame_start();
        test_level_bits_clamp();
        test_width_zero();
        test_width_shrink_mid_row();
        test_random_frames(165);
        set_idling(53, 32);
        test_random_frames(165);
        set_idling(0, 0);
        test_receiver_hold();
        test_random_frames(165);
        test_width_beyond_max();
        wait_idle();
        $display("Run covered %0d pixel transfers, %0d results and %0d configurations,",
                 pixel_count, result_count, config_count);
        $display("including out-of-range settings, an oversized line width and a long output stall.");
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
